FILE: rtl/core/tsmt_pkg.sv
package tsmt_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int WORD_BITS     = 32;

  localparam int IDX_BITS = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_BITS = $clog2(TABLE_ENTRIES + 1);

  localparam int ADDR_BITS     = 32;
  localparam int FIELD_BITS    = 32;
  localparam int IN_DATA_BITS  = 72;
  localparam int OUT_DATA_BITS = 40;
  localparam int RAM_BITS      = WORD_BITS + 1;

  typedef enum logic {
    OP_STORE = 1'b0,
    OP_LOAD  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_DONE
  } state_t;

endpackage

FILE: rtl/core/tainted_sparse_memory_table.sv
// Tainted sparse memory table: an associative store of up to TABLE_ENTRIES
// words, each with a one-bit taint mark, keyed by a 32-bit address.
//
// Request channel (s_*): s_tuser carries op (store or load). A store writes
// value and taint into the entry holding the address, or takes a new entry;
// with the table full the store is dropped and full_error is set. A load
// returns the entry's value and taint with found set, or the default_value
// register, untainted, with found clear.
// Result channel (m_*): exactly one result per request, in request order.
// APB port: register default_value at byte address 0.
//
// Timing: a request is taken, its address compared against all stored
// addresses in parallel and the match registered, then the value RAM is
// read or written and the result registered. No new request is taken
// until that result is in the output register, which lets a new request
// in while a result waits; a stalled receiver holds the result and the
// block stops before producing the next one.
// Reset empties the table and clears default_value; no clearing pass.
module tainted_sparse_memory_table (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // [31:0] address, [63:32] write_value, [64] write_taint, [71:65] zero
  input  logic [tsmt_pkg::IN_DATA_BITS-1:0]   s_tdata,
  // [0] op
  input  logic [0:0]                          s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [31:0] read_value, [32] read_taint, [33] found, [34] full_error, [39:35] zero
  output logic [tsmt_pkg::OUT_DATA_BITS-1:0]  m_tdata,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [2:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  tsmt_pkg::state_t state, state_next;

  logic                              op;
  logic [tsmt_pkg::ADDR_BITS-1:0]    addr;
  logic [tsmt_pkg::WORD_BITS-1:0]    wval;
  logic                              wtaint;
  logic [tsmt_pkg::TABLE_ENTRIES-1:0] hit_vec, hit_vec_next;
  logic [tsmt_pkg::ADDR_BITS-1:0]    cam [tsmt_pkg::TABLE_ENTRIES];
  logic [tsmt_pkg::CNT_BITS-1:0]     used;
  logic                              found;
  logic                              full_err;
  logic [tsmt_pkg::WORD_BITS-1:0]    default_value;

  logic                              hit;
  logic [tsmt_pkg::IDX_BITS-1:0]     hit_idx;
  logic                              table_full;
  logic                              accept;
  logic                              out_free;
  logic                              insert;

  logic                              ram_we;
  logic [tsmt_pkg::IDX_BITS-1:0]     ram_waddr;
  logic                              ram_re;
  logic [tsmt_pkg::RAM_BITS-1:0]     ram_rdata;

  logic [tsmt_pkg::FIELD_BITS-1:0]   res_value;
  logic                              res_taint;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? 32'(default_value) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      default_value <= '0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      default_value <= tsmt_pkg::WORD_BITS'(pwdata);
    end
  end

  assign accept     = s_tvalid && s_tready;
  assign out_free   = !m_tvalid || m_tready;
  assign table_full = (used == tsmt_pkg::CNT_BITS'(tsmt_pkg::TABLE_ENTRIES));

  // parallel address compare against the entries in use
  always_comb begin
    for (int i = 0; i < tsmt_pkg::TABLE_ENTRIES; i++) begin
      hit_vec_next[i] = (tsmt_pkg::CNT_BITS'(i) < used) && (cam[i] == s_tdata[31:0]);
    end
  end

  // addresses are unique among used entries, so at most one bit is set
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < tsmt_pkg::TABLE_ENTRIES; i++) begin
      if (hit_vec[i]) begin
        hit_idx = hit_idx | tsmt_pkg::IDX_BITS'(i);
      end
    end
  end

  assign hit    = |hit_vec;
  assign insert = (state == tsmt_pkg::ST_LOOKUP) && (op == tsmt_pkg::OP_STORE) && !hit &&
                  !table_full;

  always_comb begin
    state_next = state;
    case (state)
      tsmt_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          state_next = tsmt_pkg::ST_LOOKUP;
        end
      end
      tsmt_pkg::ST_LOOKUP: begin
        state_next = tsmt_pkg::ST_DONE;
      end
      tsmt_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = tsmt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = tsmt_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    s_tready  = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = hit_idx;
    case (state)
      tsmt_pkg::ST_IDLE: begin
        s_tready = 1'b1;
      end
      tsmt_pkg::ST_LOOKUP: begin
        if (op == tsmt_pkg::OP_LOAD) begin
          ram_re = hit;
        end else begin
          ram_we = hit || !table_full;
          if (!hit) begin
            ram_waddr = used[tsmt_pkg::IDX_BITS-1:0];
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tsmt_pkg::ST_IDLE;
      used  <= '0;
    end else begin
      state <= state_next;
      if (insert) begin
        used <= used + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op      <= s_tuser[0];
      addr    <= s_tdata[31:0];
      wval    <= tsmt_pkg::WORD_BITS'(s_tdata[63:32]);
      wtaint  <= s_tdata[64];
      hit_vec <= hit_vec_next;
    end
    if (state == tsmt_pkg::ST_LOOKUP) begin
      found    <= hit;
      full_err <= (op == tsmt_pkg::OP_STORE) && !hit && table_full;
    end
    if (insert) begin
      cam[used[tsmt_pkg::IDX_BITS-1:0]] <= addr;
    end
  end

  tsmt_ram #(
    .DEPTH(tsmt_pkg::TABLE_ENTRIES),
    .WIDTH(tsmt_pkg::RAM_BITS)
  ) u_value_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata({wtaint, wval}),
    .re   (ram_re),
    .raddr(hit_idx),
    .rdata(ram_rdata)
  );

  always_comb begin
    res_value = '0;
    res_taint = 1'b0;
    if (op == tsmt_pkg::OP_LOAD) begin
      if (found) begin
        res_value = tsmt_pkg::FIELD_BITS'(ram_rdata[tsmt_pkg::WORD_BITS-1:0]);
        res_taint = ram_rdata[tsmt_pkg::WORD_BITS];
      end else begin
        res_value = tsmt_pkg::FIELD_BITS'(default_value);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == tsmt_pkg::ST_DONE) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == tsmt_pkg::ST_DONE) && out_free) begin
      m_tdata <= {5'd0, full_err, found, res_taint, res_value};
    end
  end

endmodule

FILE: rtl/core/tsmt_ram.sv
module tsmt_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 33
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [$clog2(DEPTH)-1:0]         waddr,
  input  logic [WIDTH-1:0]                 wdata,
  input  logic                             re,
  input  logic [$clog2(DEPTH)-1:0]         raddr,
  output logic [WIDTH-1:0]                 rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/tsmt_checker.sv
module tsmt_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                s_tvalid,
  input logic                                s_tready,
  input logic                                m_tvalid,
  input logic                                m_tready,
  input logic [tsmt_pkg::OUT_DATA_BITS-1:0]  m_tdata
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // a dropped store reports nothing else
  a_full_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[34] |-> m_tdata[33:0] == 34'd0)
    else $error("full_error with other fields set");

  // taint only comes from a matched entry
  a_taint_found: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[32] |-> m_tdata[33])
    else $error("read_taint without found");

  // one request in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken back to back");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind tainted_sparse_memory_table tsmt_checker u_checker (.*);

FILE: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam logic [2:0] REG_DEFAULT_VALUE = 3'd0;
  localparam int STALL_LIMIT = 2000;
  localparam int DIRECTED_COUNT = 14;

  typedef struct packed {
    logic [31:0] value;
    logic        taint;
    logic        found;
    logic        full;
  } access_result_t;

  typedef struct packed {
    tsmt_pkg::op_t  op;
    logic [31:0]    addr;
    logic [31:0]    wval;
    logic           wtaint;
    logic           known;
    access_result_t known_res;
  } directed_row_t;

  localparam directed_row_t DIRECTED_ACCESSES [DIRECTED_COUNT] = '{
    '{tsmt_pkg::OP_LOAD,  32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1,
      '{32'h0000_0000, 1'b0, 1'b0, 1'b0}},
    '{tsmt_pkg::OP_LOAD,  32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b1,
      '{32'h0000_0000, 1'b0, 1'b0, 1'b0}},
    '{tsmt_pkg::OP_STORE, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1,
      '{32'h0000_0000, 1'b0, 1'b0, 1'b0}},
    '{tsmt_pkg::OP_LOAD,  32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1,
      '{32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0}},
    '{tsmt_pkg::OP_STORE, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b1,
      '{32'h0000_0000, 1'b0, 1'b0, 1'b0}},
    '{tsmt_pkg::OP_LOAD,  32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b1,
      '{32'h0000_0000, 1'b0, 1'b1, 1'b0}},
    '{tsmt_pkg::OP_STORE, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1,
      '{32'h0000_0000, 1'b0, 1'b1, 1'b0}},
    '{tsmt_pkg::OP_LOAD,  32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 1'b1,
      '{32'h0000_0000, 1'b0, 1'b1, 1'b0}},
    '{tsmt_pkg::OP_STORE, 32'h8000_0000, 32'hA5A5_A5A5, 1'b1, 1'b0, '0},
    '{tsmt_pkg::OP_LOAD,  32'h8000_0000, 32'h0000_0000, 1'b0, 1'b0, '0},
    '{tsmt_pkg::OP_LOAD,  32'h0000_0001, 32'h0000_0000, 1'b0, 1'b0, '0},
    '{tsmt_pkg::OP_STORE, 32'hFFFF_FFFF, 32'h1234_5678, 1'b1, 1'b0, '0},
    '{tsmt_pkg::OP_LOAD,  32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, '0},
    '{tsmt_pkg::OP_LOAD,  32'h7FFF_FFFF, 32'h0000_0000, 1'b0, 1'b0, '0}
  };

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               s_tvalid = 1'b0;
  logic                               s_tready;
  logic [tsmt_pkg::IN_DATA_BITS-1:0]  s_tdata = '0;
  logic [0:0]                         s_tuser = '0;
  logic                               m_tvalid;
  logic                               m_tready = 1'b0;
  logic [tsmt_pkg::OUT_DATA_BITS-1:0] m_tdata;
  logic                               psel = 1'b0;
  logic                               penable = 1'b0;
  logic                               pwrite = 1'b0;
  logic [2:0]                         paddr = '0;
  logic [31:0]                        pwdata = '0;
  logic [31:0]                        prdata;
  logic                               pready;

  logic [31:0] shadow_addr  [tsmt_pkg::TABLE_ENTRIES];
  logic [31:0] shadow_value [tsmt_pkg::TABLE_ENTRIES];
  logic        shadow_taint [tsmt_pkg::TABLE_ENTRIES];
  logic        shadow_valid [tsmt_pkg::TABLE_ENTRIES];
  int          shadow_used = 0;
  logic [31:0] shadow_default = '0;

  access_result_t awaited_results[$];
  int sent_count = 0;
  int recv_count = 0;
  int mismatch_count = 0;
  int idle_cycles = 0;

  tainted_sparse_memory_table DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tainted_sparse_memory_table regression: fail");
      $finish;
    end
  end

  function automatic void report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("mismatch %0d at %0t: %s expected %h got %h", mismatch_count, $realtime, what,
               want, got);
    end
  endfunction

  function automatic access_result_t shadow_access(tsmt_pkg::op_t op, logic [31:0] addr,
                                                   logic [31:0] wval, logic wtaint);
    access_result_t res;
    int hit;
    res = '0;
    hit = -1;
    for (int k = 0; k < shadow_used; k++) begin
      if (hit < 0 && shadow_valid[k] && shadow_addr[k] == addr) begin
        hit = k;
      end
    end
    if (op == tsmt_pkg::OP_STORE) begin
      if (hit >= 0) begin
        shadow_value[hit] = wval;
        shadow_taint[hit] = wtaint;
        res.found = 1'b1;
      end else if (shadow_used < tsmt_pkg::TABLE_ENTRIES) begin
        shadow_addr[shadow_used]  = addr;
        shadow_value[shadow_used] = wval;
        shadow_taint[shadow_used] = wtaint;
        shadow_valid[shadow_used] = 1'b1;
        shadow_used++;
      end else begin
        res.full = 1'b1;
      end
    end else if (hit >= 0) begin
      res.value = shadow_value[hit];
      res.taint = shadow_taint[hit];
      res.found = 1'b1;
    end else begin
      res.value = shadow_default;
    end
    return res;
  endfunction

  task automatic send_access(input tsmt_pkg::op_t op, input logic [31:0] addr,
                             input logic [31:0] wval,
                             input logic wtaint, input logic known,
                             input access_result_t known_res);
    int gap;
    access_result_t predicted;
    gap = (((sent_count / 40) % 4) == 3) ? 0 : $urandom_range(0, 14);
    if ($urandom_range(0, 63) == 0) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while (awaited_results.size() != 0);
    end else if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, wtaint, wval, addr};
    s_tuser  <= op;
    do @(posedge clk); while (s_tready !== 1'b1);
    predicted = shadow_access(op, addr, wval, wtaint);
    awaited_results.push_back(known ? known_res : predicted);
    sent_count++;
  endtask

  task automatic set_default_value(input logic [31:0] val);
    s_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_DEFAULT_VALUE;
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    shadow_default = val;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== val) begin
      report_mismatch("default_value readback", val, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // fresh_pct: share of stores aimed at an address not yet in the table
  task automatic random_phase(input int items, input int fresh_pct);
    tsmt_pkg::op_t op;
    logic [31:0] addr;
    logic [31:0] wval;
    int pick;
    int bit_idx;
    for (int n = 0; n < items; n++) begin
      op = $urandom_range(0, 1) ? tsmt_pkg::OP_LOAD : tsmt_pkg::OP_STORE;
      pick = $urandom_range(0, 99);
      if (shadow_used == 0 || pick < ((op == tsmt_pkg::OP_STORE) ? fresh_pct : 20)) begin
        addr = $urandom;
      end else begin
        addr = shadow_addr[$urandom_range(0, shadow_used - 1)];
        if (pick < ((op == tsmt_pkg::OP_STORE) ? fresh_pct + 10 : 35)) begin
          bit_idx = $urandom_range(0, 31);
          addr[bit_idx] = ~addr[bit_idx];
        end
      end
      case ($urandom_range(0, 9))
        0:       wval = 32'h0000_0000;
        1:       wval = 32'hFFFF_FFFF;
        default: wval = $urandom;
      endcase
      send_access(op, addr, wval, 1'($urandom_range(0, 1)), 1'b0, '0);
    end
  endtask

  initial begin : result_sink
    int stall;
    logic [tsmt_pkg::OUT_DATA_BITS-1:0] beat;
    access_result_t want;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      stall = (((recv_count / 50) % 4) == 2) ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1);
      beat = m_tdata;
      recv_count++;
      if (awaited_results.size() == 0) begin
        report_mismatch("result with no request pending", '0, beat[31:0]);
      end else begin
        want = awaited_results.pop_front();
        if (beat[31:0] !== want.value) report_mismatch("read_value", want.value, beat[31:0]);
        if (beat[32] !== want.taint) report_mismatch("read_taint", 32'(want.taint), 32'(beat[32]));
        if (beat[33] !== want.found) report_mismatch("found", 32'(want.found), 32'(beat[33]));
        if (beat[34] !== want.full) report_mismatch("full_error", 32'(want.full), 32'(beat[34]));
        if (beat[39:35] !== 5'd0) report_mismatch("tdata pad", '0, 32'(beat[39:35]));
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int i = 0; i < DIRECTED_COUNT; i++) begin
      send_access(DIRECTED_ACCESSES[i].op, DIRECTED_ACCESSES[i].addr,
                  DIRECTED_ACCESSES[i].wval, DIRECTED_ACCESSES[i].wtaint,
                  DIRECTED_ACCESSES[i].known, DIRECTED_ACCESSES[i].known_res);
    end
    set_default_value(32'hFFFF_FFFF);
    random_phase(484, 8);
    set_default_value($urandom);
    random_phase(484, 8);
    set_default_value(32'h0000_0000);
    random_phase(484, 8);
    // heavy insertion: table fills up and stores start to overflow
    set_default_value({1'b1, 31'($urandom)});
    random_phase(484, 40);
    s_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tainted_sparse_memory_table regression: pass");
    end else begin
      $display("tainted_sparse_memory_table regression: fail");
    end
    $finish;
  end

endmodule
